FILE: hw/rtl/asmp_pkg.sv
// package: payload types, controller commands and axis helpers for the sample magnitude peak block
`timescale 1ns / 1ps

package asmp_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned QTR_W  = 11;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned ROOT_W = 12;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CNT_W  = 4;

  localparam int unsigned SIGN_BIT  = 13;
  localparam int unsigned ONE_G_BIT = 12;

  localparam logic [WORD_W-1:0] POS_CLAMP = 16'h0FFF;
  localparam logic [WORD_W-1:0] NEG_CLAMP = 16'h3001;

  // last count value of the squarer and root sequencer phases
  localparam logic [CNT_W-1:0] SQ_LAST   = 4'd3;
  localparam logic [CNT_W-1:0] ROOT_LAST = 4'd11;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_sel_t;

  typedef struct packed {
    logic [WORD_W-1:0] raw_x;
    logic [WORD_W-1:0] raw_y;
    logic [WORD_W-1:0] raw_z;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] clamped_x;
    logic [WORD_W-1:0] clamped_y;
    logic [WORD_W-1:0] clamped_z;
    logic [ROOT_W-1:0] magnitude;
    logic [ROOT_W-1:0] peak_magnitude;
  } out_beat_t;

  typedef struct packed {
    logic      load_in;
    logic      mul_en;
    axis_sel_t mul_sel;
    logic      acc_en;
    logic      root_step;
    logic      out_load;
  } asmp_cmd_t;

  // 13-bit magnitude of a 14-bit two's complement word, divided by four
  function automatic logic [QTR_W-1:0] axis_quarter(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] neg;
    begin
      neg = ~w + 16'd1;
      if (w[SIGN_BIT]) begin
        axis_quarter = neg[12:2];
      end else begin
        axis_quarter = w[12:2];
      end
    end
  endfunction

  function automatic logic [WORD_W-1:0] axis_clamp(input logic [WORD_W-1:0] w);
    begin
      if (!w[SIGN_BIT] && w[ONE_G_BIT]) begin
        axis_clamp = POS_CLAMP;
      end else if (w[SIGN_BIT] && !w[ONE_G_BIT]) begin
        axis_clamp = NEG_CLAMP;
      end else begin
        axis_clamp = w;
      end
    end
  endfunction

endpackage

FILE: hw/rtl/asmp_datapath.sv
// datapath: sample capture, shared squarer, accumulator, bit-serial square root, peak and output register
`timescale 1ns / 1ps

module asmp_datapath import asmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_data,
  input  asmp_cmd_t cmd,
  output out_beat_t out_data
);

  in_beat_t           in_r;
  logic [QTR_W-1:0]   q_sel;
  logic [2*QTR_W-1:0] prod_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [ROOT_W-1:0]  peak_r, peak_nxt;
  out_beat_t          out_r;

  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   rem_diff;

  always_comb begin
    case (cmd.mul_sel)
      AXIS_X:  q_sel = axis_quarter(in_r.raw_x);
      AXIS_Y:  q_sel = axis_quarter(in_r.raw_y);
      AXIS_Z:  q_sel = axis_quarter(in_r.raw_z);
      default: q_sel = '0;
    endcase
  end

  // one root bit per step: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    rem_sh   = {rem_r, sum_r[SUM_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    rem_diff = rem_sh - trial;
    sum_nxt  = sum_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (cmd.load_in) begin
      sum_nxt  = '0;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (cmd.acc_en) begin
      sum_nxt = sum_r + {{(SUM_W-2*QTR_W){1'b0}}, prod_r};
    end else if (cmd.root_step) begin
      sum_nxt = {sum_r[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_diff[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    peak_nxt = peak_r;
    if (cmd.out_load && (root_r > peak_r)) begin
      peak_nxt = root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else begin
      peak_r <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.mul_en) begin
      prod_r <= q_sel * q_sel;
    end
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (cmd.out_load) begin
      out_r.clamped_x      <= axis_clamp(in_r.raw_x);
      out_r.clamped_y      <= axis_clamp(in_r.raw_y);
      out_r.clamped_z      <= axis_clamp(in_r.raw_z);
      out_r.magnitude      <= root_r;
      out_r.peak_magnitude <= peak_nxt;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hw/rtl/asmp_ctrl.sv
// controller: sequencer that steps the squarer and square root and owns both handshakes
`timescale 1ns / 1ps

module asmp_ctrl import asmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output asmp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SQ,
    S_ROOT,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_take;
  logic             out_free;

  assign in_take  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.mul_sel = AXIS_X;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        // product of step n is added in step n + 1
        cmd.mul_en  = (cnt_r != SQ_LAST);
        cmd.mul_sel = axis_sel_t'(cnt_r[1:0]);
        cmd.acc_en  = (cnt_r != '0);
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_ROOT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == ROOT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SQ))
    else $error("accepted beat did not start the squarer");

  a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (cnt_r <= ROOT_LAST))
    else $error("root step count overran");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("result overwrote a stalled output beat");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("output valid rose outside the done state");
`endif

endmodule

FILE: hw/rtl/accel_sample_magnitude_peak.sv
// top level: three-axis sample clamp, vector magnitude and running peak
`timescale 1ns / 1ps

//  channel | ports                         | payload     | beat when
//  --------+-------------------------------+-------------+---------------------------
//  input   | in_valid, in_stall, in_data   | in_beat_t   | in_valid && !in_stall
//  result  | out_valid, out_stall, out_data| out_beat_t  | out_valid && !out_stall
//
//  one sample at a time: accept, the shared 11x11 squarer and accumulator, the
//  bit-serial root and the output load run in order, and no new beat is taken until
//  the result is loaded; the root loop makes one result bit per cycle over 12 bits
//  synchronous active-low reset clears the sequencer, output valid and the peak to zero
//  a stalled result sits in the output register while the next sample is taken and
//  computed; only the final load waits on out_stall

module accel_sample_magnitude_peak import asmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // commands from the sequencer into the datapath
  asmp_cmd_t cmd;

  asmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // magnitude is taken from unclamped words; clamp happens at output load
  asmp_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
